// ----- rtl/pcrsh_pkg.sv -----
// ---------------------------------------------------------------------------
// pcrsh_pkg
// Shared types and codes for the pc range sample histogram: request kinds,
// result status codes, field widths and the input and result word layouts.
// ---------------------------------------------------------------------------
package pcrsh_pkg;

  localparam int REQ_W    = 2;
  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 13;
  localparam int OFF_W    = 12;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 32;
  localparam int LEN_W    = 13;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_REGISTER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SAMPLE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ     = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOROOM  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OFFSET  = 2'd3;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] block_size;
    logic [ADDR_W-1:0] addr;
    logic [REQ_W-1:0]  req_type;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0]    block_length;
    logic [CNT_W-1:0]    count_value;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

// ----- rtl/pcrsh_ram.sv -----
// ---------------------------------------------------------------------------
// pcrsh_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data, no reset.
// ---------------------------------------------------------------------------
module pcrsh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pcrsh_ctrl.sv -----
// ---------------------------------------------------------------------------
// pcrsh_ctrl
// Sequencer for the histogram: clears the counter store after reset, walks
// the range table one entry per probe through a single compare unit, then
// reads one counter and, for a sample, updates it.
// ---------------------------------------------------------------------------
module pcrsh_ctrl #(
  parameter int MAX_RANGES  = 16,
  parameter int POOL_WORDS  = 4096,
  parameter int ADDR_WIDTH  = 32,
  parameter int COUNT_WIDTH = 32,
  localparam int RIDX = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1,
  localparam int PIDX = $clog2(POOL_WORDS),
  localparam int PNW  = $clog2(POOL_WORDS + 1),
  localparam int TW   = 2 * ADDR_WIDTH + PNW
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pcrsh_pkg::item_t        in_item,
  output logic                    res_valid,
  input  logic                    res_ready,
  output pcrsh_pkg::result_t      res,
  // range table port
  output logic                    tbl_we,
  output logic [RIDX-1:0]         tbl_waddr,
  output logic [TW-1:0]           tbl_wdata,
  output logic [RIDX-1:0]         tbl_raddr,
  input  logic [TW-1:0]           tbl_rdata,
  // counter store port
  output logic                    cnt_we,
  output logic [PIDX-1:0]         cnt_waddr,
  output logic [COUNT_WIDTH-1:0]  cnt_wdata,
  output logic [PIDX-1:0]         cnt_raddr,
  input  logic [COUNT_WIDTH-1:0]  cnt_rdata
);

  localparam int AW   = ADDR_WIDTH;
  localparam int RCW  = $clog2(MAX_RANGES + 1);
  localparam int SUMW = ((PNW > pcrsh_pkg::SIZE_W) ? PNW : pcrsh_pkg::SIZE_W) + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TBL_RD,
    S_TBL_CMP,
    S_CNT_RD,
    S_CNT_UPD,
    S_FIN
  } state_t;

  state_t                          state;
  logic [PIDX-1:0]                 clr_addr;
  logic [RCW-1:0]                  range_count;
  logic [RIDX-1:0]                 last_hit_index;
  logic                            last_hit_valid;
  logic [PNW-1:0]                  pool_next;
  logic [pcrsh_pkg::REQ_W-1:0]     req;
  logic [AW-1:0]                   a;
  logic [pcrsh_pkg::OFF_W-1:0]     off;
  logic [RIDX-1:0]                 walk_idx;
  logic                            walk_lh;
  logic [PIDX-1:0]                 cnt_idx;
  logic [pcrsh_pkg::LEN_W-1:0]     hit_len;

  logic [AW-1:0]          in_a;
  logic [SUMW-1:0]        pool_sum;
  logic                   room;
  logic [AW-1:0]          t_start;
  logic [AW-1:0]          t_end;
  logic [PNW-1:0]         t_base;
  logic [AW-1:0]          t_span;
  logic                   t_holds;
  logic                   t_same;
  logic [COUNT_WIDTH-1:0] cnt_inc;

  always_comb begin
    in_a     = AW'(in_item.addr);
    pool_sum = SUMW'(pool_next) + SUMW'(in_item.block_size);
    room     = (range_count < RCW'(MAX_RANGES)) && (pool_sum <= SUMW'(POOL_WORDS));
    t_start  = tbl_rdata[AW-1:0];
    t_end    = tbl_rdata[2*AW-1:AW];
    t_base   = tbl_rdata[TW-1:2*AW];
    t_span   = t_end - t_start;
    t_holds  = (a >= t_start) && (a < t_end);
    t_same   = (a == t_start);
    // saturating increment
    cnt_inc  = (&cnt_rdata) ? cnt_rdata : cnt_rdata + 1'b1;
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_FIN);

  assign tbl_we    = (state == S_IDLE) && in_valid &&
                     (in_item.req_type == pcrsh_pkg::REQ_REGISTER) && room;
  assign tbl_waddr = range_count[RIDX-1:0];
  assign tbl_wdata = {pool_next, in_a + AW'(in_item.block_size), in_a};
  assign tbl_raddr = walk_idx;

  assign cnt_we    = (state == S_CLEAR) ||
                     ((state == S_CNT_UPD) && (req == pcrsh_pkg::REQ_SAMPLE));
  assign cnt_waddr = (state == S_CLEAR) ? clr_addr : cnt_idx;
  assign cnt_wdata = (state == S_CLEAR) ? '0 : cnt_inc;
  assign cnt_raddr = cnt_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      range_count    <= '0;
      last_hit_index <= '0;
      last_hit_valid <= 1'b0;
      pool_next      <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == PIDX'(POOL_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            req      <= in_item.req_type;
            a        <= in_a;
            off      <= in_item.offset;
            walk_idx <= RIDX'(range_count - 1'b1);
            walk_lh  <= 1'b0;
            res      <= '{block_length: '0, count_value: '0,
                          status: pcrsh_pkg::ST_NOMATCH};
            state    <= S_FIN;
            case (in_item.req_type)
              pcrsh_pkg::REQ_REGISTER: begin
                if (room) begin
                  range_count <= range_count + 1'b1;
                  pool_next   <= PNW'(pool_sum);
                  res <= '{block_length: in_item.block_size, count_value: '0,
                           status: pcrsh_pkg::ST_OK};
                end else begin
                  res <= '{block_length: '0, count_value: '0,
                           status: pcrsh_pkg::ST_NOROOM};
                end
              end
              pcrsh_pkg::REQ_SAMPLE: begin
                if (last_hit_valid && (RCW'(last_hit_index) < range_count)) begin
                  walk_idx <= last_hit_index;
                  walk_lh  <= 1'b1;
                  state    <= S_TBL_RD;
                end else if (range_count != '0) begin
                  state <= S_TBL_RD;
                end
              end
              pcrsh_pkg::REQ_READ: begin
                if (range_count != '0) begin
                  state <= S_TBL_RD;
                end
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end

        S_TBL_RD: begin
          state <= S_TBL_CMP;
        end

        S_TBL_CMP: begin
          hit_len <= pcrsh_pkg::LEN_W'(t_span);
          if (req == pcrsh_pkg::REQ_SAMPLE) begin
            if (t_holds) begin
              if (!walk_lh) begin
                last_hit_index <= walk_idx;
                last_hit_valid <= 1'b1;
              end
              cnt_idx <= PIDX'(t_base) + PIDX'(a - t_start);
              state   <= S_CNT_RD;
            end else if (walk_lh) begin
              // last-hit probe missed, fall back to the newest-first walk
              walk_idx <= RIDX'(range_count - 1'b1);
              walk_lh  <= 1'b0;
              state    <= S_TBL_RD;
            end else if (walk_idx == '0) begin
              state <= S_FIN;
            end else begin
              walk_idx <= walk_idx - 1'b1;
              state    <= S_TBL_RD;
            end
          end else begin
            if (t_same) begin
              if (AW'(off) >= t_span) begin
                res <= '{block_length: pcrsh_pkg::LEN_W'(t_span), count_value: '0,
                         status: pcrsh_pkg::ST_OFFSET};
                state <= S_FIN;
              end else begin
                cnt_idx <= PIDX'(t_base) + PIDX'(off);
                state   <= S_CNT_RD;
              end
            end else if (walk_idx == '0) begin
              state <= S_FIN;
            end else begin
              walk_idx <= walk_idx - 1'b1;
              state    <= S_TBL_RD;
            end
          end
        end

        S_CNT_RD: begin
          state <= S_CNT_UPD;
        end

        S_CNT_UPD: begin
          if (req == pcrsh_pkg::REQ_SAMPLE) begin
            res <= '{block_length: hit_len,
                     count_value: pcrsh_pkg::CNT_W'(cnt_inc),
                     status: pcrsh_pkg::ST_OK};
          end else begin
            res <= '{block_length: hit_len,
                     count_value: pcrsh_pkg::CNT_W'(cnt_rdata),
                     status: pcrsh_pkg::ST_OK};
          end
          state <= S_FIN;
        end

        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/pc_range_sample_histogram_top.sv -----
// ---------------------------------------------------------------------------
// pc_range_sample_histogram_top
// PC-sampling histogram: register code ranges, count samples per byte with
// saturating counters, read counters back. Stream in, stream out.
// ---------------------------------------------------------------------------
// register: answered straight from idle, as is a sample or read with an empty
//   table; otherwise the table is probed one entry at a time, newest first (a
//   sample tries its last hit first; up to MAX_RANGES + 1 entries on a sample)
//   and a hit reads the counter; one word at a time, the next taken once the result is handed on
// reset: synchronous; clears the table and pool pointers, then a clearing
//   pass zeroes all POOL_WORDS counters with s_tready low
module pc_range_sample_histogram_top #(
  parameter int MAX_RANGES  = 16,
  parameter int POOL_WORDS  = 4096,
  parameter int ADDR_WIDTH  = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // req_type, addr, block_size, offset from bit 0 up, top bits unused
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // status, count_value, block_length, zero fill
);

  localparam int RIDX = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int PIDX = $clog2(POOL_WORDS);
  localparam int PNW  = $clog2(POOL_WORDS + 1);
  localparam int TW   = 2 * ADDR_WIDTH + PNW;
  localparam int IW   = $bits(pcrsh_pkg::item_t);
  localparam int RW   = $bits(pcrsh_pkg::result_t);

  pcrsh_pkg::item_t   item;
  pcrsh_pkg::result_t res;
  pcrsh_pkg::result_t out_word;
  logic               res_valid;
  logic               res_ready;

  logic                   tbl_we;
  logic [RIDX-1:0]        tbl_waddr;
  logic [TW-1:0]          tbl_wdata;
  logic [RIDX-1:0]        tbl_raddr;
  logic [TW-1:0]          tbl_rdata;
  logic                   cnt_we;
  logic [PIDX-1:0]        cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic [PIDX-1:0]        cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_rdata;

  assign item = s_tdata[IW-1:0];

  // output slot frees up when the current word is taken
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign m_tdata = {{(48 - RW){1'b0}}, out_word};

  pcrsh_ctrl #(
    .MAX_RANGES  (MAX_RANGES),
    .POOL_WORDS  (POOL_WORDS),
    .ADDR_WIDTH  (ADDR_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .tbl_we    (tbl_we),
    .tbl_waddr (tbl_waddr),
    .tbl_wdata (tbl_wdata),
    .tbl_raddr (tbl_raddr),
    .tbl_rdata (tbl_rdata),
    .cnt_we    (cnt_we),
    .cnt_waddr (cnt_waddr),
    .cnt_wdata (cnt_wdata),
    .cnt_raddr (cnt_raddr),
    .cnt_rdata (cnt_rdata)
  );

  // range table: {base, end, start}
  pcrsh_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_RANGES)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  pcrsh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (POOL_WORDS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

endmodule
